// ===== rtl/core/hdtm_pkg.sv =====
// Shared types and constants for the heading-to-track drive mixer.
package hdtm_pkg;

  // Track command codes carried on the result channel.
  typedef enum logic [1:0] {
    CMD_FORWARD = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_BRAKE   = 2'd2
  } cmd_t;

  // Result of the final scaling step for one track.
  typedef struct packed {
    logic [7:0] speed;
    cmd_t       cmd;
  } trk_t;

  // Configuration register map (byte address bit 2 selects the register).
  typedef enum logic {
    REG_FLOOR_SPEED = 1'b0,
    REG_TOP_SPEED   = 1'b1
  } reg_idx_t;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [7:0] FLOOR_SPEED_RST = 8'd0;
  localparam logic [7:0] TOP_SPEED_RST   = 8'd255;

  // Heading normalization bounds.
  localparam logic signed [10:0] DEG_360 = 11'sd360;
  localparam logic signed [10:0] DEG_720 = 11'sd720;
  localparam logic signed [10:0] DEG_M360 = -11'sd360;

  // Curve breakpoints in normalized degrees.
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;

  // Power is taken modulo this value.
  localparam logic [6:0] POWER_MOD = 7'd101;

  // Curve numerator: raw = (RAMP_TOP - RAMP_SLOPE * t) / 3.
  localparam logic signed [11:0] RAMP_TOP   = 12'sd765;
  localparam logic [4:0]         RAMP_SLOPE = 5'd17;

  // Reciprocal constants for exact truncating division by constants.
  localparam logic [9:0]  RECIP3     = 10'd683;    // ceil(2^11 / 3)
  localparam logic [12:0] RECIP100   = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [16:0] RECIP255   = 17'd65794;  // ceil(2^24 / 255)

endpackage

// ===== rtl/core/hdtm_in_if.sv =====
// Input channel of the drive mixer: heading and power with valid/ready.
interface hdtm_in_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] heading_degrees;
  logic [6:0]        power_level;

  modport source (output valid, output heading_degrees, output power_level, input ready);
  modport sink   (input valid, input heading_degrees, input power_level, output ready);
endinterface

// ===== rtl/core/hdtm_out_if.sv =====
// Result channel of the drive mixer: per-track speed and command with valid/ready.
interface hdtm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_speed;
  logic [1:0] left_command;
  logic [7:0] right_speed;
  logic [1:0] right_command;

  modport source (output valid, output left_speed, output left_command,
                  output right_speed, output right_command, input ready);
  modport sink   (input valid, input left_speed, input left_command,
                  input right_speed, input right_command, output ready);
endinterface

// ===== rtl/core/heading_to_track_drive_mixer_core.sv =====
// Top level of the heading-to-track drive mixer: six-stage pipeline and register port.
//
// The block turns a heading in degrees and a power level in percent into a
// speed and a forward/reverse/brake command for each of two tracks.
// Items enter on in_ch (valid/ready) and leave on out_ch (valid/ready), one
// result item for each input item, in order.
// An accepted item passes through the registers of stages 1 to 6 in order and
// is presented on out_ch from the stage 6 output register.
// Throughput is one item per cycle while out_ch is ready;
// the path is a six-stage pipeline whose deepest stages are the constant
// reciprocal multipliers (divide by 3, by 100 and by 255).
// When out_ch stalls, the last stage holds its item and each earlier stage
// keeps moving until it runs into a full stage; empty stages are filled, so
// in_ch stays ready as long as any bubble remains in the pipe.
// Registers floor_speed (address 0) and top_speed (address 4) are written over
// the APB-style port; pready is always high and reads return the value.
// They feed the pipeline directly; the user must change them only while it is empty,
// which the block itself does not enforce. Synchronous reset (rst_n low) empties
// the pipeline and sets floor_speed to 0 and top_speed to 255.
module heading_to_track_drive_mixer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  hdtm_in_if.sink                       in_ch,
  hdtm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdtm_pkg::PADDR_W-1:0]  paddr,
  input  logic [hdtm_pkg::PDATA_W-1:0]  pwdata,
  output logic [hdtm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [7:0] floor_speed_r;
  logic [7:0] top_speed_r;
  logic       cfg_wr;
  hdtm_pkg::reg_idx_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = hdtm_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_speed_r <= hdtm_pkg::FLOOR_SPEED_RST;
      top_speed_r   <= hdtm_pkg::TOP_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        hdtm_pkg::REG_FLOOR_SPEED: floor_speed_r <= pwdata[7:0];
        hdtm_pkg::REG_TOP_SPEED:   top_speed_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      hdtm_pkg::REG_FLOOR_SPEED: prdata = {{(hdtm_pkg::PDATA_W-8){1'b0}}, floor_speed_r};
      hdtm_pkg::REG_TOP_SPEED:   prdata = {{(hdtm_pkg::PDATA_W-8){1'b0}}, top_speed_r};
      default:                   prdata = '0;
    endcase
  end

  // lo = floor_speed - 1 sets the bottom of the scaled range; span is the
  // distance from lo up to top_speed, which may be negative.
  logic signed [9:0] lo;
  logic signed [9:0] span;
  assign lo   = $signed({2'b00, floor_speed_r}) - 10'sd1;
  assign span = $signed({2'b00, top_speed_r}) - lo;

  // ------------------------------------------------------------------
  // Pipeline flow control: a stage advances when it is empty or when the
  // stage after it advances.
  // ------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_ch.ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: reduce the heading to 0..359 and the power modulo 101.
  // Headings span -512..511, so at most one step of 720 or 360 is needed.
  // ------------------------------------------------------------------
  logic signed [10:0] h_ext;
  logic signed [10:0] h_norm;
  logic [8:0]         d_nxt;
  logic [6:0]         p_nxt;
  logic [8:0]         s1_d_r;
  logic [6:0]         s1_p_r;

  assign h_ext = {in_ch.heading_degrees[9], in_ch.heading_degrees};

  always_comb begin
    priority if (h_ext >= hdtm_pkg::DEG_360) begin
      h_norm = h_ext - hdtm_pkg::DEG_360;
    end else if (h_ext >= 11'sd0) begin
      h_norm = h_ext;
    end else if (h_ext >= hdtm_pkg::DEG_M360) begin
      h_norm = h_ext + hdtm_pkg::DEG_360;
    end else begin
      h_norm = h_ext + hdtm_pkg::DEG_720;
    end
  end

  assign d_nxt = h_norm[8:0];
  assign p_nxt = (in_ch.power_level >= hdtm_pkg::POWER_MOD)
               ? in_ch.power_level - hdtm_pkg::POWER_MOD
               : in_ch.power_level;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d_r <= d_nxt;
      s1_p_r <= p_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: curve numerators for both tracks (three times the raw value),
  // and the power product that sets the speed ceiling.
  // ------------------------------------------------------------------
  function automatic logic signed [11:0] ramp_f(input logic [8:0] t);
    logic [10:0] m;
    m = 11'(t[6:0]) * 11'(hdtm_pkg::RAMP_SLOPE);
    return hdtm_pkg::RAMP_TOP - $signed({1'b0, m});
  endfunction

  logic signed [11:0] lnum;
  logic signed [11:0] rnum;
  logic [9:0]         lmag_nxt;
  logic [9:0]         rmag_nxt;
  logic               sneg;
  logic [8:0]         smag;
  logic [15:0]        cprod;

  logic [9:0]  s2_lmag_r;
  logic [9:0]  s2_rmag_r;
  logic        s2_lneg_r;
  logic        s2_rneg_r;
  logic [14:0] s2_cprod_r;
  logic        s2_cneg_r;

  always_comb begin
    priority if (s1_d_r <= hdtm_pkg::DEG_90) begin
      lnum = hdtm_pkg::RAMP_TOP;
      rnum = -ramp_f(s1_d_r);
    end else if (s1_d_r <= hdtm_pkg::DEG_180) begin
      lnum = ramp_f(s1_d_r - hdtm_pkg::DEG_90);
      rnum = hdtm_pkg::RAMP_TOP;
    end else if (s1_d_r <= hdtm_pkg::DEG_270) begin
      lnum = -hdtm_pkg::RAMP_TOP;
      rnum = ramp_f(s1_d_r - hdtm_pkg::DEG_180);
    end else begin
      lnum = -ramp_f(s1_d_r - hdtm_pkg::DEG_270);
      rnum = -hdtm_pkg::RAMP_TOP;
    end
  end

  assign lmag_nxt = lnum[11] ? 10'(-lnum) : 10'(lnum);
  assign rmag_nxt = rnum[11] ? 10'(-rnum) : 10'(rnum);

  assign sneg  = span[9];
  assign smag  = sneg ? 9'(-span) : 9'(span);
  assign cprod = 16'(s1_p_r) * 16'(smag);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_lmag_r  <= lmag_nxt;
      s2_rmag_r  <= rmag_nxt;
      s2_lneg_r  <= lnum[11];
      s2_rneg_r  <= rnum[11];
      s2_cprod_r <= cprod[14:0];
      s2_cneg_r  <= sneg;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: divide the numerators by 3 and the power product by 100,
  // both by exact reciprocal multiplication on magnitudes, which gives
  // truncation toward zero once the sign is put back.
  // ------------------------------------------------------------------
  logic [19:0] lq3;
  logic [19:0] rq3;
  logic [27:0] cq100;

  logic [7:0] s3_lraw_r;
  logic [7:0] s3_rraw_r;
  logic       s3_lpos_r;
  logic       s3_rpos_r;
  logic [8:0] s3_cmag_r;
  logic       s3_cneg_r;

  assign lq3   = 20'(s2_lmag_r) * 20'(hdtm_pkg::RECIP3);
  assign rq3   = 20'(s2_rmag_r) * 20'(hdtm_pkg::RECIP3);
  assign cq100 = 28'(s2_cprod_r) * 28'(hdtm_pkg::RECIP100);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_lraw_r <= lq3[18:11];
      s3_rraw_r <= rq3[18:11];
      // A raw value counts as positive only when it is nonzero after truncation.
      s3_lpos_r <= !s2_lneg_r && (lq3[18:11] != 8'd0);
      s3_rpos_r <= !s2_rneg_r && (rq3[18:11] != 8'd0);
      s3_cmag_r <= cq100[27:19];
      s3_cneg_r <= s2_cneg_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: raw magnitude times (ceiling - lo).
  // ------------------------------------------------------------------
  logic [15:0] s4_lprod_r;
  logic [15:0] s4_rprod_r;
  logic        s4_lpos_r;
  logic        s4_rpos_r;
  logic        s4_cneg_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_lprod_r <= 16'(s3_lraw_r) * 16'(s3_cmag_r);
      s4_rprod_r <= 16'(s3_rraw_r) * 16'(s3_cmag_r);
      s4_lpos_r  <= s3_lpos_r;
      s4_rpos_r  <= s3_rpos_r;
      s4_cneg_r  <= s3_cneg_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: divide the products by 255.
  // ------------------------------------------------------------------
  logic [32:0] lq255;
  logic [32:0] rq255;

  logic [8:0] s5_lq_r;
  logic [8:0] s5_rq_r;
  logic       s5_lpos_r;
  logic       s5_rpos_r;
  logic       s5_cneg_r;

  assign lq255 = 33'(s4_lprod_r) * 33'(hdtm_pkg::RECIP255);
  assign rq255 = 33'(s4_rprod_r) * 33'(hdtm_pkg::RECIP255);

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_lq_r   <= lq255[32:24];
      s5_rq_r   <= rq255[32:24];
      s5_lpos_r <= s4_lpos_r;
      s5_rpos_r <= s4_rpos_r;
      s5_cneg_r <= s4_cneg_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: add lo, apply the raw sign, and decide brake, forward or
  // reverse. This stage is the output register.
  // ------------------------------------------------------------------
  function automatic hdtm_pkg::trk_t finish_f(
    input logic [8:0]        q,
    input logic              cneg,
    input logic              pos,
    input logic signed [9:0] lo_v,
    input logic [7:0]        mins
  );
    logic signed [10:0] qs;
    logic signed [10:0] w;
    logic [9:0]         mag;
    hdtm_pkg::trk_t     r;
    qs  = cneg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    w   = qs + 11'(lo_v);
    mag = w[10] ? 10'(-w) : 10'(w);
    if ((mag < {2'b00, mins}) || (w == 11'sd0)) begin
      r.speed = 8'd0;
      r.cmd   = hdtm_pkg::CMD_BRAKE;
    end else begin
      r.speed = mag[7:0];
      // The signed result is positive when the raw sign and w agree.
      r.cmd   = (pos == !w[10]) ? hdtm_pkg::CMD_FORWARD : hdtm_pkg::CMD_REVERSE;
    end
    return r;
  endfunction

  hdtm_pkg::trk_t left_nxt;
  hdtm_pkg::trk_t right_nxt;
  hdtm_pkg::trk_t s6_left_r;
  hdtm_pkg::trk_t s6_right_r;

  assign left_nxt  = finish_f(s5_lq_r, s5_cneg_r, s5_lpos_r, lo, floor_speed_r);
  assign right_nxt = finish_f(s5_rq_r, s5_cneg_r, s5_rpos_r, lo, floor_speed_r);

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_left_r  <= left_nxt;
      s6_right_r <= right_nxt;
    end
  end

  assign out_ch.valid         = v6_r;
  assign out_ch.left_speed    = s6_left_r.speed;
  assign out_ch.left_command  = s6_left_r.cmd;
  assign out_ch.right_speed   = s6_right_r.speed;
  assign out_ch.right_command = s6_right_r.cmd;

endmodule
